>>> rtl/core/ectt_pkg.sv
`timescale 1ns / 1ps
package ectt_pkg;

  typedef enum logic [2:0] {
    CMD_RECORD = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_NEWEST = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_WALK   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  cause_code;
    logic [63:0] parent_id;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [31:0] source_line;
    logic [63:0] query_id;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] record_id;
    logic [7:0]  out_cause;
    logic [63:0] out_time;
    logic [63:0] out_parent;
    logic [63:0] out_a;
    logic [63:0] out_b;
    logic [31:0] out_line;
    logic [6:0]  chain_length;
    logic        last_in_run;
  } rsp_t;

  // One slot of the ring, minus the id.
  typedef struct packed {
    logic [7:0]  cause;
    logic [63:0] stamp;
    logic [63:0] parent;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [31:0] line;
  } entry_t;

endpackage

>>> rtl/core/ectt_req_if.sv
`timescale 1ns / 1ps
interface ectt_req_if;
  import ectt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ectt_rsp_if.sv
`timescale 1ns / 1ps
interface ectt_rsp_if;
  import ectt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/ectt_ctrl.sv
`timescale 1ns / 1ps
module ectt_ctrl
  import ectt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned MAX_CHAIN   = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    enable_i,
  ectt_req_if.sink   req,
  ectt_rsp_if.source rsp
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int unsigned LW = $clog2(MAX_CHAIN + 1);
  localparam rsp_t NONE_RSP = '{last_in_run: 1'b1, default: '0};

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CMP, ST_EMIT_RD, ST_EMIT_LAT, ST_OUT
  } state_e;

  typedef enum logic [1:0] {MODE_LOOKUP, MODE_WALK_FIND, MODE_WALK_EMIT} mode_e;

  // Memories
  logic [63:0] id_mem [TABLE_DEPTH];
  entry_t      ent_mem [TABLE_DEPTH];
  logic [AW-1:0] stack_mem [MAX_CHAIN];

  state_e        state_q;
  mode_e         mode_q;
  logic [AW-1:0] wslot_q;
  logic [FW-1:0] filled_q;
  logic [63:0]   next_id_q;
  logic [63:0]   time_q;
  logic [FW-1:0] scan_q;
  logic [63:0]   target_q;
  logic [LW-1:0] depth_q;
  logic [LW-1:0] emit_q;
  logic [AW-1:0] hit_slot_q;
  logic [63:0]   rd_id_q;
  entry_t        rd_ent_q;
  logic [AW-1:0] stack_rd_q;
  logic          out_valid_q;
  rsp_t          out_q;

  logic [AW-1:0] rd_addr;
  logic          id_match;

  assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_q;
  assign id_match  = (rd_id_q == target_q);

  always_comb begin
    rd_addr = scan_q[AW-1:0];
    if (state_q == ST_EMIT_LAT || state_q == ST_EMIT_RD || state_q == ST_OUT) begin
      rd_addr = hit_slot_q;
    end
    if (state_q == ST_EMIT_LAT && mode_q == MODE_WALK_EMIT) rd_addr = stack_rd_q;
  end

  // Slot memory: single write port, single registered read.
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready && req.data.command == CMD_RECORD && enable_i) begin
      id_mem[wslot_q]  <= next_id_q;
      ent_mem[wslot_q] <= '{cause: req.data.cause_code, stamp: time_q + 64'd1,
                             parent: req.data.parent_id, op_a: req.data.operand_a,
                             op_b: req.data.operand_b, line: req.data.source_line};
    end
    rd_id_q  <= id_mem[rd_addr];
    rd_ent_q <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN_CMP && mode_q == MODE_WALK_FIND && id_match
        && scan_q < filled_q) begin
      stack_mem[depth_q[CW-1:0]] <= scan_q[AW-1:0];
    end
    stack_rd_q <= stack_mem[emit_q[CW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_LOOKUP;
      wslot_q     <= '0;
      filled_q    <= '0;
      next_id_q   <= 64'd1;
      time_q      <= '0;
      scan_q      <= '0;
      target_q    <= '0;
      depth_q     <= '0;
      emit_q      <= '0;
      hit_slot_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && rsp.ready && !(state_q == ST_OUT && mode_q != MODE_WALK_FIND)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            unique case (req.data.command)
              CMD_RECORD: begin
                if (enable_i) begin
                  wslot_q   <= (wslot_q == AW'(TABLE_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
                  if (filled_q != FW'(TABLE_DEPTH)) filled_q <= filled_q + 1'b1;
                  next_id_q <= next_id_q + 64'd1;
                  time_q    <= time_q + 64'd1;
                  out_q     <= '{found: 1'b1, record_id: next_id_q,
                                 out_cause: req.data.cause_code, out_time: time_q + 64'd1,
                                 out_parent: req.data.parent_id,
                                 out_a: req.data.operand_a, out_b: req.data.operand_b,
                                 out_line: req.data.source_line, chain_length: '0,
                                 last_in_run: 1'b1};
                end else begin
                  out_q <= NONE_RSP;
                end
                out_valid_q <= 1'b1;
              end
              CMD_LOOKUP, CMD_WALK: begin
                mode_q   <= (req.data.command == CMD_LOOKUP) ? MODE_LOOKUP : MODE_WALK_FIND;
                target_q <= req.data.query_id;
                scan_q   <= '0;
                depth_q  <= '0;
                if (req.data.query_id == 64'd0 || filled_q == '0) begin
                  out_q <= NONE_RSP;
                  out_valid_q <= 1'b1;
                end else begin
                  state_q <= ST_SCAN_RD;
                end
              end
              CMD_NEWEST: begin
                if (filled_q == '0) begin
                  out_q <= NONE_RSP;
                  out_valid_q <= 1'b1;
                end else begin
                  mode_q     <= MODE_LOOKUP;
                  hit_slot_q <= (wslot_q == '0) ? AW'(TABLE_DEPTH - 1) : wslot_q - 1'b1;
                  state_q    <= ST_EMIT_RD;
                end
              end
              CMD_CLEAR: begin
                wslot_q  <= '0;
                filled_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN_RD: state_q <= ST_SCAN_CMP;
        ST_SCAN_CMP: begin
          if (id_match) begin
            hit_slot_q <= scan_q[AW-1:0];
            if (mode_q == MODE_LOOKUP) begin
              state_q <= ST_EMIT_RD;
            end else begin
              depth_q <= depth_q + 1'b1;
              state_q <= ST_EMIT_RD;
            end
          end else if (scan_q + 1'b1 >= filled_q) begin
            if (mode_q == MODE_LOOKUP || depth_q == '0) begin
              out_q       <= NONE_RSP;
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              mode_q  <= MODE_WALK_EMIT;
              emit_q  <= depth_q - 1'b1;
              state_q <= ST_EMIT_RD;
            end
          end else begin
            scan_q  <= scan_q + 1'b1;
            state_q <= ST_SCAN_RD;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_LAT;
        ST_EMIT_LAT: begin
          if (mode_q == MODE_WALK_EMIT) hit_slot_q <= stack_rd_q;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (mode_q == MODE_WALK_FIND) begin
            // read done for this hop; follow parent
            if (rd_ent_q.parent == 64'd0 || depth_q == LW'(MAX_CHAIN)) begin
              mode_q  <= MODE_WALK_EMIT;
              emit_q  <= depth_q - 1'b1;
              state_q <= ST_EMIT_RD;
            end else begin
              target_q <= rd_ent_q.parent;
              scan_q   <= '0;
              state_q  <= ST_SCAN_RD;
            end
          end else if (!out_valid_q || rsp.ready) begin
            out_q <= '{found: 1'b1, record_id: rd_id_q, out_cause: rd_ent_q.cause,
                       out_time: rd_ent_q.stamp, out_parent: rd_ent_q.parent,
                       out_a: rd_ent_q.op_a, out_b: rd_ent_q.op_b, out_line: rd_ent_q.line,
                       chain_length: (mode_q == MODE_WALK_EMIT) ? 7'(depth_q) : 7'd0,
                       last_in_run: (mode_q != MODE_WALK_EMIT) || (emit_q == '0)};
            out_valid_q <= 1'b1;
            if (mode_q == MODE_WALK_EMIT && emit_q != '0) begin
              emit_q  <= emit_q - 1'b1;
              state_q <= ST_EMIT_RD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FW'(TABLE_DEPTH)) else $error("fill count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= LW'(MAX_CHAIN)) else $error("chain depth overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp.ready) |=> $stable(out_q)) else $error("result changed");

endmodule

>>> rtl/core/error_cause_trace_table_top.sv
`timescale 1ns / 1ps
// Circular error-cause trace log with one request and one response channel.
// Record and clear are served in idle; newest reads the latest slot through
// EMIT_RD, EMIT_LAT and OUT. Lookup scans filled slots in order, each through
// SCAN_RD and SCAN_CMP, then reads a hit through the same emit states, all via
// a single memory read port; a chain walk repeats that scan per hop, then emits
// entries root first, each waiting in OUT while the response is held. No new
// request is taken until the last response leaves.
// Configuration write enable sets tracking; disabled records return id zero.
module error_cause_trace_table_top
  import ectt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned MAX_CHAIN   = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  ectt_req_if.sink   req,
  ectt_rsp_if.source rsp
);

  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  ectt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CHAIN(MAX_CHAIN)) u_ctrl (
    .clk_i, .rst_ni, .enable_i(enable_q), .req(req), .rsp(rsp)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import ectt_pkg::*;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned WALK_MAX = 64;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'(CMD_WALK) + 3'd1;
  localparam logic [2:0] CMD_LAST_UNUSED = 3'h7;

  class trace_scoreboard;
    logic [63:0] ids [RING_DEPTH];
    entry_t      slots [RING_DEPTH];
    int unsigned wr_slot;
    int unsigned filled;
    logic [63:0] next_id;
    logic [63:0] stamp;
    bit          enabled;
    rsp_t        expected_q [$];
    int unsigned errors;

    function new();
      wr_slot = 0;
      filled = 0;
      next_id = 64'd1;
      stamp = 64'd0;
      enabled = 1'b1;
      errors = 0;
    endfunction

    function int find(logic [63:0] id);
      if (id == 64'd0) return -1;
      for (int i = 0; i < filled; i++) if (ids[i] == id) return i;
      return -1;
    endfunction

    function rsp_t entry_rsp(int s, logic [6:0] len, bit last);
      rsp_t r;
      r = '0;
      if (s >= 0) begin
        r.found = 1'b1;
        r.record_id = ids[s];
        r.out_cause = slots[s].cause;
        r.out_time = slots[s].stamp;
        r.out_parent = slots[s].parent;
        r.out_a = slots[s].op_a;
        r.out_b = slots[s].op_b;
        r.out_line = slots[s].line;
      end
      r.chain_length = len;
      r.last_in_run = last;
      return r;
    endfunction

    // Accepted request: advance the ring and queue the responses it causes.
    function void note_request(req_t q);
      int s;
      int chain [$];
      logic [63:0] cur;
      case (q.command)
        CMD_RECORD: begin
          if (!enabled) expected_q.push_back(entry_rsp(-1, 7'd0, 1'b1));
          else begin
            s = wr_slot;
            ids[s] = next_id;
            next_id = next_id + 64'd1;
            stamp = stamp + 64'd1;
            slots[s].stamp = stamp;
            slots[s].cause = q.cause_code;
            slots[s].parent = q.parent_id;
            slots[s].op_a = q.operand_a;
            slots[s].op_b = q.operand_b;
            slots[s].line = q.source_line;
            wr_slot = (s + 1) % RING_DEPTH;
            if (filled < RING_DEPTH) filled++;
            expected_q.push_back(entry_rsp(s, 7'd0, 1'b1));
          end
        end
        CMD_LOOKUP: expected_q.push_back(entry_rsp(find(q.query_id), 7'd0, 1'b1));
        CMD_NEWEST: begin
          s = (filled == 0) ? -1 : int'((wr_slot + RING_DEPTH - 1) % RING_DEPTH);
          expected_q.push_back(entry_rsp(s, 7'd0, 1'b1));
        end
        CMD_CLEAR: begin
          wr_slot = 0;
          filled = 0;
        end
        CMD_WALK: begin
          cur = q.query_id;
          while (cur != 64'd0 && chain.size() < WALK_MAX) begin
            s = find(cur);
            if (s < 0) break;
            chain.push_back(s);
            cur = slots[s].parent;
          end
          if (chain.size() == 0) expected_q.push_back(entry_rsp(-1, 7'd0, 1'b1));
          for (int i = chain.size() - 1; i >= 0; i--)
            expected_q.push_back(entry_rsp(chain[i], 7'(chain.size()), i == 0));
        end
        default: ;
      endcase
    endfunction

    function void field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected response, expected none actual %h", $time, a);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      field("found", 64'(e.found), 64'(a.found));
      field("record_id", e.record_id, a.record_id);
      field("out_cause", 64'(e.out_cause), 64'(a.out_cause));
      field("out_time", e.out_time, a.out_time);
      field("out_parent", e.out_parent, a.out_parent);
      field("out_a", e.out_a, a.out_a);
      field("out_b", e.out_b, a.out_b);
      field("out_line", 64'(e.out_line), 64'(a.out_line));
      field("chain_length", 64'(e.chain_length), 64'(a.chain_length));
      field("last_in_run", 64'(e.last_in_run), 64'(a.last_in_run));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  bit idle_en;
  bit hold_go;
  bit hold_done;
  int hold_left;
  int rsp_gap;
  longint unsigned cycles;
  trace_scoreboard sb;

  ectt_req_if req ();
  ectt_rsp_if rsp ();

  error_cause_trace_table_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req.sink),
    .rsp        (rsp.source)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) sb.check_response(rsp.data);
  end

  // Response side back-pressure: random bursts plus one long hold-off.
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rsp_gap = $urandom_range(0, 4);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t mk_req(logic [2:0] cmd, logic [63:0] parent, logic [63:0] qid);
    req_t r;
    r.command = cmd;
    r.cause_code = 8'($urandom);
    r.parent_id = parent;
    r.operand_a = rand64();
    r.operand_b = rand64();
    r.source_line = $urandom;
    r.query_id = qid;
    return r;
  endfunction

  // Ends on a falling edge after the transaction; valid stays high unless a random idle gap is inserted.
  task automatic send(req_t r);
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk_i); while (!req.ready);
    sb.note_request(r);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_tracking(bit v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.enabled = v;
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] pick_id(bit for_parent);
    logic [63:0] base;
    int unsigned sel;
    base = sb.next_id;
    sel = $urandom_range(0, 99);
    if (sel < 65) return base - 64'($urandom_range(1, 10));
    if (sel < 75) return for_parent ? base + 64'($urandom_range(0, 3))
                                    : base - 64'($urandom_range(11, 90));
    if (sel < 85) return 64'd0;
    return rand64();
  endfunction

  task automatic random_items(int n);
    int unsigned sel;
    int done;
    done = 0;
    while (done < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) send(mk_req(CMD_RECORD, pick_id(1), rand64()));
      else if (sel < 62) send(mk_req(CMD_LOOKUP, rand64(), pick_id(0)));
      else if (sel < 70) send(mk_req(CMD_NEWEST, rand64(), rand64()));
      else if (sel < 73) send(mk_req(CMD_CLEAR, rand64(), rand64()));
      else if (sel < 95) send(mk_req(CMD_WALK, rand64(), pick_id(0)));
      else begin
        send(mk_req(3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED)), rand64(), rand64()));
        continue;
      end
      done++;
      if (n - done == 40) idle_en = 1'b0;
    end
  endtask

  initial begin
    req_t r;
    sb = new();
    cycles = 0;
    idle_en = 1'b1;
    hold_go = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    rsp_gap = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_tracking(1'b1);
    send(mk_req(CMD_NEWEST, '0, '0));
    send(mk_req(CMD_WALK, '0, '0));
    r = '0;
    send(r);
    r = '1;
    r.command = CMD_RECORD;
    send(r);
    send(mk_req(CMD_LOOKUP, '0, 64'd0));
    send(mk_req(CMD_LOOKUP, '0, 64'd1));
    send(mk_req(CMD_LOOKUP, '0, '1));
    send(mk_req(CMD_RECORD, 64'd2, '0));
    send(mk_req(CMD_RECORD, 64'd3, '0));
    send(mk_req(CMD_WALK, '0, 64'd4));
    send(mk_req(CMD_NEWEST, '0, '0));
    // self-referencing record: walk runs to the depth limit
    send(mk_req(CMD_RECORD, sb.next_id, '0));
    send(mk_req(CMD_WALK, '0, sb.next_id - 64'd1));
    send(mk_req(CMD_LAST_UNUSED, '0, '0));
    send(mk_req(CMD_FIRST_UNUSED, '0, '0));
    send(mk_req(CMD_CLEAR, '0, '0));
    send(mk_req(CMD_NEWEST, '0, '0));
    send(mk_req(CMD_LOOKUP, '0, 64'd1));
    send(mk_req(CMD_WALK, '0, 64'd4));
    send(mk_req(CMD_RECORD, 64'd0, '0));
    drain();
    write_tracking(1'b0);
    send(mk_req(CMD_RECORD, 64'd1, '0));
    send(mk_req(CMD_NEWEST, '0, '0));
    drain();
    write_tracking(1'b1);

    // fill past the ring depth so slots wrap, then walk back through them
    for (int i = 0; i < 70; i++) send(mk_req(CMD_RECORD, sb.next_id - 64'd1, '0));
    hold_go = 1'b1;
    send(mk_req(CMD_WALK, '0, sb.next_id - 64'd1));
    random_items(80);
    drain();
    write_tracking(1'b0);
    idle_en = 1'b1;
    random_items(30);
    drain();
    write_tracking(1'b1);
    idle_en = 1'b1;
    random_items(70);
    drain();
    repeat (300) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
